### sv/pttt_pkg.sv
// Shared types, constants and helper functions for the pan/tilt target tracker.
// Used by pttt_divider and pan_tilt_target_tracker; depends on nothing else.
package pttt_pkg;

    // Action codes carried in the input transaction.
    typedef enum logic [1:0] {
        ACT_RESET_AIM   = 2'd0,
        ACT_ONE_SHOT    = 2'd1,
        ACT_TRACK_LATCH = 2'd2,
        ACT_TRACK_FREE  = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_QUALITY_MIN    = 3'd0;
    localparam logic [2:0] CFG_LOCK_BAND      = 3'd1;
    localparam logic [2:0] CFG_STEP_DIVISOR   = 3'd2;
    localparam logic [2:0] CFG_SERVO_MIN      = 3'd3;
    localparam logic [2:0] CFG_SERVO_MAX      = 3'd4;
    localparam logic [2:0] CFG_SERVO_CENTER   = 3'd5;
    localparam logic [2:0] CFG_LOCK_TICKS     = 3'd6;
    localparam logic [2:0] CFG_PULSE_LENGTH   = 3'd7;

    // Configuration reset values.
    localparam logic [7:0]  RST_QUALITY_MIN  = 8'd50;
    localparam logic [14:0] RST_LOCK_BAND    = 15'd8;
    localparam logic [7:0]  RST_STEP_DIVISOR = 8'd8;
    localparam logic [7:0]  RST_SERVO_MIN    = 8'd30;
    localparam logic [7:0]  RST_SERVO_MAX    = 8'd150;
    localparam logic [7:0]  RST_SERVO_CENTER = 8'd90;
    localparam logic [15:0] RST_LOCK_TICKS   = 16'd10;
    localparam logic [15:0] RST_PULSE_LENGTH = 16'd500;

    localparam int DVD_W = 16;
    localparam int DVS_W = 8;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Magnitude of a signed 16-bit error; the most negative value maps to 32768.
    function automatic logic [15:0] err_mag(input logic [15:0] e);
        err_mag = e[15] ? (~e + 16'd1) : e;
    endfunction

    // New angle for one axis from its quotient, with at least one degree of motion,
    // clamped against the lower limit first and then the upper one.
    function automatic logic [7:0] axis_next(input logic [7:0] angle, input logic neg,
                                             input logic [15:0] q, input logic [7:0] smin,
                                             input logic [7:0] smax);
        logic [15:0]       q1;
        logic signed [17:0] stp;
        logic signed [17:0] v;
        q1  = (q == 16'd0) ? 16'd1 : q;
        stp = $signed({2'b00, q1});
        v   = $signed({10'd0, angle}) + (neg ? -stp : stp);
        if (v < $signed({10'd0, smin})) begin
            axis_next = smin;
        end else if (v > $signed({10'd0, smax})) begin
            axis_next = smax;
        end else begin
            axis_next = v[7:0];
        end
    endfunction

endpackage

### sv/pttt_divider.sv
// Restoring serial divider, one quotient bit per cycle, shared by both axes.
// Depends on pttt_pkg for widths and the status struct.
module pttt_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pttt_pkg::DVD_W-1:0]  dividend,
    input  logic [pttt_pkg::DVS_W-1:0]  divisor,
    output logic [pttt_pkg::DVD_W-1:0]  quotient,
    output pttt_pkg::div_stat_t         stat
);

    localparam int CNT_W = $clog2(pttt_pkg::DVD_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [pttt_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [pttt_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [pttt_pkg::DVS_W-1:0]  dvs_reg, dvs_next;
    logic [pttt_pkg::DVS_W:0]    trial;
    logic [pttt_pkg::DVS_W:0]    diff;
    logic                        take;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[pttt_pkg::DVD_W-1]};
        take      = (trial >= {1'b0, dvs_reg});
        diff      = trial - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            // A zero divisor behaves as one.
            dvs_next  = (divisor == '0) ? {{(pttt_pkg::DVS_W-1){1'b0}}, 1'b1} : divisor;
        end else if (busy_reg) begin
            rem_next = take ? diff[pttt_pkg::DVS_W-1:0] : trial[pttt_pkg::DVS_W-1:0];
            dvd_next = {dvd_reg[pttt_pkg::DVD_W-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(pttt_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held longer than one cycle");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

endmodule

### sv/pan_tilt_target_tracker.sv
// Top level of the pan/tilt target tracker: configuration registers, sequencer and state.
// Depends on pttt_pkg and pttt_divider.
//
//  Channel  Direction  Contents
//  s_       in         tuser: action, target_fresh; tdata: now_ms, target_x, target_y, quality
//  m_       out        tdata: pan_angle, tilt_angle, laser_on, fired, aim_complete, no_target
//  cfg_     in         cfg_index selects one of eight registers, cfg_data carries the value
//
// Acceptance starts the divider on the pan error, and the result is loaded from the final state;
// the serial divider runs 16 iterations for the pan error and then 16 for the tilt error.
// The input is accepted only while the sequencer is idle; a result waits in the output
// register, and the next transaction may be accepted while it waits.
// A stalled result holds the sequencer in its final state until the register frees.
// Reset clears the control state and loads the configuration defaults.
module pan_tilt_target_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] target_fresh
    input  logic [71:0] s_tdata,   // [31:0] now_ms, [47:32] target_x, [63:48] target_y,
                                   // [71:64] target_quality
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] pan_angle, [15:8] tilt_angle, [16] laser_on,
                                   // [17] fired, [18] aim_complete, [19] no_target, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIVX   = 4'b0010,
        S_DIVY   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  qmin_reg;
    logic [14:0] band_reg;
    logic [7:0]  sdiv_reg;
    logic [7:0]  smin_reg;
    logic [7:0]  smax_reg;
    logic [7:0]  scen_reg;
    logic [15:0] need_reg;
    logic [15:0] plen_reg;

    logic [1:0]  act_reg;
    logic [31:0] now_reg;
    logic        fresh_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [7:0]  qual_reg;
    logic [15:0] qx_reg, qy_reg;

    logic [7:0]  pan_reg, pan_next;
    logic [7:0]  tilt_reg, tilt_next;
    logic [15:0] lock_reg, lock_next;
    logic [31:0] pend_reg, pend_next;
    logic        pact_reg, pact_next;
    logic        shot_reg, shot_next;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic        div_start;
    logic [15:0] div_dvd;
    logic [15:0] div_quot;
    pttt_pkg::div_stat_t div_stat;

    logic        in_acc, out_free, commit;
    logic [15:0] mag_x, mag_y;
    logic        expired, pact_kept, good, track, on_target, lock_met;
    logic        fire, done, bad, latch;
    logic [15:0] lock_inc;

    pttt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (sdiv_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit    = (state_reg == S_FINISH) && out_free;
    assign cfg_ready = 1'b1;

    assign mag_x = pttt_pkg::err_mag(x_reg);
    assign mag_y = pttt_pkg::err_mag(y_reg);

    // Sequencer and divider control.
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_dvd    = mag_y;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    div_start  = 1'b1;
                    div_dvd    = pttt_pkg::err_mag(s_tdata[47:32]);
                    state_next = S_DIVX;
                end
            end
            S_DIVX: begin
                if (div_stat.done) begin
                    div_start  = 1'b1;
                    state_next = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_stat.done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Tick update, applied when the result is loaded.
    always_comb begin
        pan_next  = pan_reg;
        tilt_next = tilt_reg;
        lock_next = lock_reg;
        pend_next = pend_reg;
        pact_next = pact_reg;
        shot_next = shot_reg;
        expired   = pact_reg && (now_reg >= pend_reg);
        pact_kept = pact_reg && !expired;
        good      = fresh_reg && (qual_reg >= qmin_reg);
        on_target = (mag_x <= {1'b0, band_reg}) && (mag_y <= {1'b0, band_reg});
        lock_inc  = (lock_reg == 16'hFFFF) ? lock_reg : lock_reg + 16'd1;
        latch     = (act_reg != pttt_pkg::ACT_TRACK_FREE);
        track     = 1'b0;
        lock_met  = 1'b0;
        fire      = 1'b0;
        done      = 1'b0;
        bad       = 1'b0;
        case (act_reg)
            pttt_pkg::ACT_RESET_AIM: begin
                pan_next  = scen_reg;
                tilt_next = scen_reg;
                lock_next = '0;
                pend_next = '0;
                pact_next = 1'b0;
                shot_next = 1'b0;
            end
            pttt_pkg::ACT_ONE_SHOT: begin
                done  = expired && shot_reg;
                track = !shot_reg;
            end
            pttt_pkg::ACT_TRACK_LATCH, pttt_pkg::ACT_TRACK_FREE: begin
                track = 1'b1;
            end
            default: begin
                track = 1'b0;
            end
        endcase
        if (act_reg != pttt_pkg::ACT_RESET_AIM) begin
            pact_next = pact_kept;
            if (expired) begin
                pend_next = '0;
            end
            if (track) begin
                if (!good) begin
                    lock_next = '0;
                    bad       = 1'b1;
                end else begin
                    if (mag_x > {1'b0, band_reg}) begin
                        pan_next = pttt_pkg::axis_next(pan_reg, x_reg[15], qx_reg,
                                                       smin_reg, smax_reg);
                    end
                    if (mag_y > {1'b0, band_reg}) begin
                        tilt_next = pttt_pkg::axis_next(tilt_reg, y_reg[15], qy_reg,
                                                        smin_reg, smax_reg);
                    end
                    lock_next = on_target ? lock_inc : '0;
                    lock_met  = (lock_next >= need_reg);
                    fire      = lock_met && !pact_kept && (!latch || !shot_reg);
                end
            end
            if (fire) begin
                pact_next = 1'b1;
                pend_next = now_reg + {16'd0, plen_reg};
                lock_next = '0;
                if (latch) begin
                    shot_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            qmin_reg     <= pttt_pkg::RST_QUALITY_MIN;
            band_reg     <= pttt_pkg::RST_LOCK_BAND;
            sdiv_reg     <= pttt_pkg::RST_STEP_DIVISOR;
            smin_reg     <= pttt_pkg::RST_SERVO_MIN;
            smax_reg     <= pttt_pkg::RST_SERVO_MAX;
            scen_reg     <= pttt_pkg::RST_SERVO_CENTER;
            need_reg     <= pttt_pkg::RST_LOCK_TICKS;
            plen_reg     <= pttt_pkg::RST_PULSE_LENGTH;
            pan_reg      <= pttt_pkg::RST_SERVO_CENTER;
            tilt_reg     <= pttt_pkg::RST_SERVO_CENTER;
            lock_reg     <= '0;
            pend_reg     <= '0;
            pact_reg     <= 1'b0;
            shot_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pttt_pkg::CFG_QUALITY_MIN:  qmin_reg <= cfg_data[7:0];
                    pttt_pkg::CFG_LOCK_BAND:    band_reg <= cfg_data[14:0];
                    pttt_pkg::CFG_STEP_DIVISOR: sdiv_reg <= cfg_data[7:0];
                    pttt_pkg::CFG_SERVO_MIN:    smin_reg <= cfg_data[7:0];
                    pttt_pkg::CFG_SERVO_MAX:    smax_reg <= cfg_data[7:0];
                    pttt_pkg::CFG_SERVO_CENTER: scen_reg <= cfg_data[7:0];
                    pttt_pkg::CFG_LOCK_TICKS:   need_reg <= cfg_data;
                    pttt_pkg::CFG_PULSE_LENGTH: plen_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (commit) begin
                pan_reg      <= pan_next;
                tilt_reg     <= tilt_next;
                lock_reg     <= lock_next;
                pend_reg     <= pend_next;
                pact_reg     <= pact_next;
                shot_reg     <= shot_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (in_acc) begin
            act_reg   <= s_tuser[1:0];
            fresh_reg <= s_tuser[2];
            now_reg   <= s_tdata[31:0];
            x_reg     <= s_tdata[47:32];
            y_reg     <= s_tdata[63:48];
            qual_reg  <= s_tdata[71:64];
        end
        if (state_reg == S_DIVX && div_stat.done) begin
            qx_reg <= div_quot;
        end
        if (state_reg == S_DIVY && div_stat.done) begin
            qy_reg <= div_quot;
        end
        if (commit) begin
            m_tdata_reg <= {4'd0, bad, done, fire, pact_next, tilt_next, pan_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result appeared without a finished transaction");
    a_fire_lights: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[17] |-> m_tdata_reg[16])
        else $error("pulse started but laser reported off");
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[18] |-> !m_tdata_reg[17] && !m_tdata_reg[16]
        && !m_tdata_reg[19]) else $error("completion mixed with other activity");
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy) else $error("input ready while divider busy");

endmodule
